// File: sv/gcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared types, constants and arithmetic helpers for the great-circle
// distance check pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

    // Pipeline sizing
    localparam int CORDIC_STAGES = 24;
    localparam int ISQRT_STEPS   = 31;
    localparam int NUM_ANGLES    = 3;

    // Angle lanes
    localparam int ANG_LAT_A = 0;
    localparam int ANG_LAT_B = 1;
    localparam int ANG_DLON  = 2;

    // Payload and internal types
    typedef logic signed [27:0] lat_t;
    typedef logic signed [28:0] lon_t;
    typedef logic        [24:0] dist_t;
    typedef logic signed [29:0] udeg_t;
    typedef logic signed [28:0] red_t;
    typedef logic        [26:0] mag_t;
    typedef logic signed [31:0] q30_t;
    typedef logic signed [33:0] vec_t;
    typedef logic signed [32:0] arc_t;
    typedef logic        [31:0] th_t;
    typedef logic        [61:0] sq_t;

    // Sideband carried with an angle through the conversion stages
    typedef struct packed {
        mag_t mag;
        logic neg;
        logic flip;
    } ang_side_t;

    // Microdegree bounds
    localparam logic signed [31:0] UDEG_90  = 32'sd90000000;
    localparam logic signed [31:0] UDEG_180 = 32'sd180000000;
    localparam logic signed [31:0] UDEG_360 = 32'sd360000000;

    // Microdegree to Q30 radians: pi*2^32 / 720e6 = 18 + DEG_B / DIV_UDEG
    localparam logic [4:0]  DEG_INT  = 5'd18;
    localparam logic [29:0] DEG_B    = 30'd533037705;
    localparam logic [29:0] DIV_UDEG = 30'd720000000;
    localparam logic [29:0] HALF_DIV = 30'd360000000;
    // floor(2^58 / 720e6)
    localparam logic [28:0] RECIP    = 29'd400319966;

    // CORDIC and output scaling
    localparam q30_t        CORDIC_K    = 32'sd652032874;
    localparam q30_t        ONE_Q30     = 32'sd1073741824;
    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [31:0] MPR_Q9      = 32'd3261795065;
    localparam logic [63:0] MPR_RND     = 64'd274877906944;
    localparam dist_t       HALF_CIRC_M = 25'd20014124;
    localparam dist_t       RADIUS_RST  = 25'd500;
    localparam sq_t         SQ_ONE      = 62'd1152921504606846976;

    // Arctangent of 2^-i in Q30
    function automatic q30_t atan_q30(input int i);
        q30_t r;
        case (i)
            0:       r = 32'sd843314857;
            1:       r = 32'sd497837829;
            2:       r = 32'sd263043837;
            3:       r = 32'sd133525159;
            4:       r = 32'sd67021687;
            5:       r = 32'sd33543516;
            6:       r = 32'sd16775851;
            7:       r = 32'sd8388437;
            8:       r = 32'sd4194283;
            9:       r = 32'sd2097149;
            default: r = (i <= 30) ? (32'sd1 <<< (30 - i)) : 32'sd0;
        endcase
        return r;
    endfunction

    // Q30 product, rounded half up
    function automatic q30_t mulq(input q30_t a, input q30_t b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        p = p + 64'sd536870912;
        return q30_t'(p >>> 30);
    endfunction

endpackage

// File: sv/gcd_angle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_angle
// Wraps microdegree angles into one half turn, folds them into a quarter
// turn and converts them to Q30 radians, three lanes side by side.
// ----------------------------------------------------------------------------
module gcd_angle (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  gcd_pkg::udeg_t ud [gcd_pkg::NUM_ANGLES],
    output logic          out_valid,
    output gcd_pkg::q30_t z [gcd_pkg::NUM_ANGLES],
    output logic [gcd_pkg::NUM_ANGLES-1:0] flip
);
    import gcd_pkg::*;

    localparam int ANG_STAGES = 9;
    localparam int SIDE_DEPTH = 6;

    logic [ANG_STAGES-1:0] vld_reg;

    udeg_t       ud_reg    [NUM_ANGLES];
    red_t        red_reg   [NUM_ANGLES];
    red_t        red_next  [NUM_ANGLES];
    ang_side_t   side_reg  [SIDE_DEPTH][NUM_ANGLES];
    ang_side_t   side_next [NUM_ANGLES];
    logic [56:0] prod_reg  [NUM_ANGLES];
    logic [56:0] prod_next [NUM_ANGLES];
    logic [55:0] tv_reg    [NUM_ANGLES];
    logic [55:0] tv_next   [NUM_ANGLES];
    logic [55:0] tq_reg    [NUM_ANGLES];
    logic [26:0] qe_reg    [NUM_ANGLES];
    logic [26:0] qe_next   [NUM_ANGLES];
    logic [26:0] qe7_reg   [NUM_ANGLES];
    logic [30:0] rem_reg   [NUM_ANGLES];
    logic [30:0] rem_next  [NUM_ANGLES];
    logic [30:0] zmag_reg  [NUM_ANGLES];
    logic [30:0] zmag_next [NUM_ANGLES];
    q30_t        z_reg     [NUM_ANGLES];
    q30_t        z_next    [NUM_ANGLES];
    logic [NUM_ANGLES-1:0] flip_reg;

    // Wrap to a half turn, then fold into a quarter turn
    always_comb begin : wrap_fold
        red_t f;
        f = '0;
        for (int l = 0; l < NUM_ANGLES; l++) begin
            if (ud_reg[l] >= UDEG_180) begin
                red_next[l] = red_t'(ud_reg[l] - UDEG_360);
            end else if (ud_reg[l] < -UDEG_180) begin
                red_next[l] = red_t'(ud_reg[l] + UDEG_360);
            end else begin
                red_next[l] = red_t'(ud_reg[l]);
            end

            if (red_reg[l] > UDEG_90) begin
                f = red_t'(UDEG_180 - red_reg[l]);
                side_next[l].flip = 1'b1;
            end else if (red_reg[l] < -UDEG_90) begin
                f = red_t'(-UDEG_180 - red_reg[l]);
                side_next[l].flip = 1'b1;
            end else begin
                f = red_reg[l];
                side_next[l].flip = 1'b0;
            end
            side_next[l].neg = f[28];
            side_next[l].mag = mag_t'(f[28] ? -f : f);
        end
    end

    // Scale to radians: fractional part by reciprocal estimate plus one correction
    always_comb begin : to_radians
        logic [58:0] qprod;
        logic [56:0] qd;
        logic [56:0] diff;
        qprod = '0;
        qd    = '0;
        diff  = '0;
        for (int l = 0; l < NUM_ANGLES; l++) begin
            prod_next[l] = {30'd0, side_reg[0][l].mag} * {27'd0, DEG_B};
            tv_next[l]   = 56'(prod_reg[l] + {27'd0, HALF_DIV});
            qprod        = {29'd0, tv_reg[l][55:26]} * {30'd0, RECIP};
            qe_next[l]   = qprod[58:32];
            qd           = {30'd0, qe_reg[l]} * {27'd0, DIV_UDEG};
            diff         = {1'b0, tq_reg[l]} - qd;
            rem_next[l]  = diff[30:0];
            zmag_next[l] = {4'd0, side_reg[4][l].mag} * {26'd0, DEG_INT}
                         + {4'd0, qe7_reg[l]}
                         + 31'(rem_reg[l] >= {1'b0, DIV_UDEG});
            z_next[l]    = side_reg[5][l].neg ? -q30_t'({1'b0, zmag_reg[l]})
                                              :  q30_t'({1'b0, zmag_reg[l]});
        end
    end

    // Advance the data stages
    always_ff @(posedge clk) begin
        if (en) begin
            for (int l = 0; l < NUM_ANGLES; l++) begin
                ud_reg[l]      <= ud[l];
                red_reg[l]     <= red_next[l];
                side_reg[0][l] <= side_next[l];
                prod_reg[l]    <= prod_next[l];
                tv_reg[l]      <= tv_next[l];
                tq_reg[l]      <= tv_reg[l];
                qe_reg[l]      <= qe_next[l];
                qe7_reg[l]     <= qe_reg[l];
                rem_reg[l]     <= rem_next[l];
                zmag_reg[l]    <= zmag_next[l];
                z_reg[l]       <= z_next[l];
                flip_reg[l]    <= side_reg[5][l].flip;
                for (int k = 1; k < SIDE_DEPTH; k++) begin
                    side_reg[k][l] <= side_reg[k-1][l];
                end
            end
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[ANG_STAGES-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[ANG_STAGES-1];
    assign z         = z_reg;
    assign flip      = flip_reg;

endmodule

// File: sv/gcd_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_sincos
// Rotation-mode CORDIC, one register stage per iteration, three lanes.
// Gives sine and cosine in Q30, cosine negated for folded angles.
// ----------------------------------------------------------------------------
module gcd_sincos (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  gcd_pkg::q30_t z [gcd_pkg::NUM_ANGLES],
    input  logic [gcd_pkg::NUM_ANGLES-1:0] flip,
    output logic          out_valid,
    output gcd_pkg::q30_t sin_q [gcd_pkg::NUM_ANGLES],
    output gcd_pkg::q30_t cos_q [gcd_pkg::NUM_ANGLES]
);
    import gcd_pkg::*;

    logic [CORDIC_STAGES:0] vld_reg;

    q30_t x_reg  [CORDIC_STAGES][NUM_ANGLES];
    q30_t y_reg  [CORDIC_STAGES][NUM_ANGLES];
    q30_t zr_reg [CORDIC_STAGES][NUM_ANGLES];
    logic fl_reg [CORDIC_STAGES][NUM_ANGLES];
    q30_t s_reg  [NUM_ANGLES];
    q30_t c_reg  [NUM_ANGLES];

    // One micro-rotation per stage
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_iter
        for (genvar l = 0; l < NUM_ANGLES; l++) begin : g_lane
            q30_t x_in;
            q30_t y_in;
            q30_t z_in;
            logic f_in;
            q30_t x_next;
            q30_t y_next;
            q30_t z_next;

            if (g == 0) begin : g_load
                assign x_in = CORDIC_K;
                assign y_in = '0;
                assign z_in = z[l];
                assign f_in = flip[l];
            end else begin : g_chain
                assign x_in = x_reg[g-1][l];
                assign y_in = y_reg[g-1][l];
                assign z_in = zr_reg[g-1][l];
                assign f_in = fl_reg[g-1][l];
            end

            // Rotate toward zero residual angle
            always_comb begin
                if (!z_in[31]) begin
                    x_next = x_in - (y_in >>> g);
                    y_next = y_in + (x_in >>> g);
                    z_next = z_in - atan_q30(g);
                end else begin
                    x_next = x_in + (y_in >>> g);
                    y_next = y_in - (x_in >>> g);
                    z_next = z_in + atan_q30(g);
                end
            end

            always_ff @(posedge clk) begin
                if (en) begin
                    x_reg[g][l]  <= x_next;
                    y_reg[g][l]  <= y_next;
                    zr_reg[g][l] <= z_next;
                    fl_reg[g][l] <= f_in;
                end
            end
        end
    end

    // Register results, undo the quarter-turn fold on cosine
    always_ff @(posedge clk) begin
        if (en) begin
            for (int l = 0; l < NUM_ANGLES; l++) begin
                s_reg[l] <= y_reg[CORDIC_STAGES-1][l];
                c_reg[l] <= fl_reg[CORDIC_STAGES-1][l] ? -x_reg[CORDIC_STAGES-1][l]
                                                       :  x_reg[CORDIC_STAGES-1][l];
            end
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[CORDIC_STAGES-1:0], in_valid};
        end
    end

    assign out_valid = vld_reg[CORDIC_STAGES];
    assign sin_q     = s_reg;
    assign cos_q     = c_reg;

endmodule

// File: sv/gcd_acos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_acos
// Arc cosine of a Q30 value: pipelined integer square root of 1 - v*v,
// then vectoring-mode CORDIC, then reflection and clamp to [0, pi].
// ----------------------------------------------------------------------------
module gcd_acos (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  gcd_pkg::q30_t v,
    output logic          out_valid,
    output gcd_pkg::th_t  th
);
    import gcd_pkg::*;

    localparam int ACOS_DEPTH = 2 + ISQRT_STEPS + CORDIC_STAGES + 1;

    logic [ACOS_DEPTH-1:0] vld_reg;

    logic [60:0] sq_reg;
    logic [30:0] ax1_reg;
    logic        neg1_reg;
    sq_t         t0_reg;
    logic [30:0] ax2_reg;
    logic        neg2_reg;

    sq_t         t_reg   [ISQRT_STEPS];
    sq_t         r_reg   [ISQRT_STEPS];
    logic [30:0] ax_reg  [ISQRT_STEPS];
    logic        ni_reg  [ISQRT_STEPS];

    vec_t        x_reg   [CORDIC_STAGES];
    vec_t        y_reg   [CORDIC_STAGES];
    arc_t        z_reg   [CORDIC_STAGES];
    logic        nv_reg  [CORDIC_STAGES];

    th_t         th_reg;
    th_t         th_next;

    logic signed [63:0] vv;

    // Square and magnitude of the cosine sum
    assign vv = 64'(v) * 64'(v);

    always_ff @(posedge clk) begin
        if (en) begin
            sq_reg   <= vv[60:0];
            ax1_reg  <= 31'(v[31] ? -v : v);
            neg1_reg <= v[31];
            t0_reg   <= SQ_ONE - {1'b0, sq_reg};
            ax2_reg  <= ax1_reg;
            neg2_reg <= neg1_reg;
        end
    end

    // Square root, one result bit per stage
    for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_sqrt
        localparam sq_t BITV = sq_t'(62'd1 << (60 - 2 * k));
        sq_t         t_in;
        sq_t         r_in;
        logic [30:0] a_in;
        logic        n_in;
        sq_t         trial;
        sq_t         t_next;
        sq_t         r_next;

        if (k == 0) begin : g_load
            assign t_in = t0_reg;
            assign r_in = '0;
            assign a_in = ax2_reg;
            assign n_in = neg2_reg;
        end else begin : g_chain
            assign t_in = t_reg[k-1];
            assign r_in = r_reg[k-1];
            assign a_in = ax_reg[k-1];
            assign n_in = ni_reg[k-1];
        end

        assign trial = r_in + BITV;

        always_comb begin
            if (t_in >= trial) begin
                t_next = t_in - trial;
                r_next = (r_in >> 1) + BITV;
            end else begin
                t_next = t_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                t_reg[k]  <= t_next;
                r_reg[k]  <= r_next;
                ax_reg[k] <= a_in;
                ni_reg[k] <= n_in;
            end
        end
    end

    // Vectoring CORDIC, one iteration per stage
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_vec
        vec_t x_in;
        vec_t y_in;
        arc_t z_in;
        logic n_in;
        vec_t x_next;
        vec_t y_next;
        arc_t z_next;

        if (g == 0) begin : g_load
            assign x_in = {3'b000, ax_reg[ISQRT_STEPS-1]};
            assign y_in = {3'b000, r_reg[ISQRT_STEPS-1][30:0]};
            assign z_in = '0;
            assign n_in = ni_reg[ISQRT_STEPS-1];
        end else begin : g_chain
            assign x_in = x_reg[g-1];
            assign y_in = y_reg[g-1];
            assign z_in = z_reg[g-1];
            assign n_in = nv_reg[g-1];
        end

        // Drive y toward zero, accumulate the angle
        always_comb begin
            if (y_in > 0) begin
                x_next = x_in + (y_in >>> g);
                y_next = y_in - (x_in >>> g);
                z_next = z_in + arc_t'(atan_q30(g));
            end else begin
                x_next = x_in - (y_in >>> g);
                y_next = y_in + (x_in >>> g);
                z_next = z_in - arc_t'(atan_q30(g));
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                x_reg[g]  <= x_next;
                y_reg[g]  <= y_next;
                z_reg[g]  <= z_next;
                nv_reg[g] <= n_in;
            end
        end
    end

    // Reflect negative sums about pi/2 and clamp to [0, pi]
    always_comb begin : reflect_clamp
        logic signed [34:0] t;
        t = nv_reg[CORDIC_STAGES-1]
          ? 35'($signed({1'b0, PI_Q30})) - 35'(z_reg[CORDIC_STAGES-1])
          : 35'(z_reg[CORDIC_STAGES-1]);
        if (t < 0) begin
            th_next = '0;
        end else if (t > 35'($signed({1'b0, PI_Q30}))) begin
            th_next = PI_Q30;
        end else begin
            th_next = th_t'(t);
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            th_reg <= th_next;
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[ACOS_DEPTH-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[ACOS_DEPTH-1];
    assign th        = th_reg;

endmodule

// File: sv/great_circle_distance_check_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_distance_check_core
// Great-circle distance between two points by the spherical law of cosines,
// in whole metres, with a below-radius flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one point pair per item:
//   lat_a, lon_a, lat_b, lon_b in signed microdegrees. Output channel
//   (out_valid / out_stall) carries distance_m and within_radius.
//   cfg_wr_en / cfg_wr_data write the radius in metres; write it only while
//   no item is in flight.
//   Throughput: one item per cycle while no stalled result holds the pipeline.
//   Every stage is a register; the work is three CORDIC-style chains
//   (24 rotation stages, 31 square-root stages, 24 vectoring stages) plus
//   multiplier stages.
//   Stall: when the output register holds a result and out_stall is high,
//   the whole pipeline freezes and in_stall rises in the same cycle;
//   nothing is lost or repeated. With no result waiting, out_stall has no
//   effect and the pipeline keeps advancing.
//   Reset: all valid bits clear, the radius returns to 500 m; the block
//   accepts items in the first cycle after reset.
// ----------------------------------------------------------------------------
module great_circle_distance_check_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  gcd_pkg::lat_t  lat_a,
    input  gcd_pkg::lon_t  lon_a,
    input  gcd_pkg::lat_t  lat_b,
    input  gcd_pkg::lon_t  lon_b,
    output logic           out_valid,
    input  logic           out_stall,
    output gcd_pkg::dist_t distance_m,
    output logic           within_radius,
    input  logic           cfg_wr_en,
    input  gcd_pkg::dist_t cfg_wr_data
);
    import gcd_pkg::*;

    logic  en;
    dist_t radius_reg;

    udeg_t ang_in [NUM_ANGLES];
    q30_t  ang_z  [NUM_ANGLES];
    logic [NUM_ANGLES-1:0] ang_flip;
    logic  ang_vld;

    q30_t  sin_q  [NUM_ANGLES];
    q30_t  cos_q  [NUM_ANGLES];
    logic  sc_vld;

    logic [2:0] p_vld_reg;
    q30_t  pss_reg;
    q30_t  pcc_reg;
    q30_t  cd_reg;
    q30_t  pss2_reg;
    q30_t  pccd_reg;
    q30_t  v_reg;
    q30_t  v_next;

    th_t   th;
    logic  ac_vld;

    logic        m_vld_reg;
    logic [63:0] mprod_reg;
    logic [63:0] mrnd;
    dist_t       dist_raw;
    dist_t       dist_next;

    logic  out_valid_reg;
    dist_t dist_reg;
    logic  within_reg;

    // Freeze every pipeline stage while a result waits on a stalled receiver
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // Radius register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            radius_reg <= RADIUS_RST;
        end else if (cfg_wr_en) begin
            radius_reg <= cfg_wr_data;
        end
    end

    // Angle lanes: both latitudes and the longitude difference
    assign ang_in[ANG_LAT_A] = udeg_t'(lat_a);
    assign ang_in[ANG_LAT_B] = udeg_t'(lat_b);
    assign ang_in[ANG_DLON]  = udeg_t'(lon_a) - udeg_t'(lon_b);

    gcd_angle u_angle (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .ud        (ang_in),
        .out_valid (ang_vld),
        .z         (ang_z),
        .flip      (ang_flip)
    );

    gcd_sincos u_sincos (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ang_vld),
        .z         (ang_z),
        .flip      (ang_flip),
        .out_valid (sc_vld),
        .sin_q     (sin_q),
        .cos_q     (cos_q)
    );

    // Cosine sum: one product level per stage, then clamp to [-1, 1]
    always_comb begin : sum_clamp
        logic signed [32:0] s;
        s = 33'(pss2_reg) + 33'(pccd_reg);
        if (s > 33'(ONE_Q30)) begin
            v_next = ONE_Q30;
        end else if (s < -33'(ONE_Q30)) begin
            v_next = -ONE_Q30;
        end else begin
            v_next = q30_t'(s);
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            pss_reg  <= mulq(sin_q[ANG_LAT_A], sin_q[ANG_LAT_B]);
            pcc_reg  <= mulq(cos_q[ANG_LAT_A], cos_q[ANG_LAT_B]);
            cd_reg   <= cos_q[ANG_DLON];
            pss2_reg <= pss_reg;
            pccd_reg <= mulq(pcc_reg, cd_reg);
            v_reg    <= v_next;
        end
    end

    gcd_acos u_acos (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p_vld_reg[2]),
        .v         (v_reg),
        .out_valid (ac_vld),
        .th        (th)
    );

    // Arc to metres, round half up, saturate at half circumference
    assign mrnd      = mprod_reg + MPR_RND;
    assign dist_raw  = mrnd[63:39];
    assign dist_next = (dist_raw > HALF_CIRC_M) ? HALF_CIRC_M : dist_raw;

    always_ff @(posedge clk) begin
        if (en) begin
            mprod_reg  <= {32'd0, th} * {32'd0, MPR_Q9};
            dist_reg   <= dist_next;
            within_reg <= dist_next < radius_reg;
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            p_vld_reg     <= '0;
            m_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            p_vld_reg     <= {p_vld_reg[1:0], sc_vld};
            m_vld_reg     <= ac_vld;
            out_valid_reg <= m_vld_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign distance_m    = dist_reg;
    assign within_radius = within_reg;

endmodule

// File: sv/gcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_checker
// Port-level checks for the great-circle distance check block, bound to
// the top level.
// ----------------------------------------------------------------------------
module gcd_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_stall,
    input logic           out_valid,
    input logic           out_stall,
    input gcd_pkg::dist_t distance_m,
    input logic           within_radius,
    input logic           cfg_wr_en,
    input gcd_pkg::dist_t cfg_wr_data
);
    import gcd_pkg::*;

    dist_t shadow_reg;

    // Track the radius as written on the port
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            shadow_reg <= RADIUS_RST;
        end else if (cfg_wr_en) begin
            shadow_reg <= cfg_wr_data;
        end
    end

    // A stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(distance_m) && $stable(within_radius))
        else $error("output item changed while stalled");

    // Distance never passes half the circumference
    a_dist_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> distance_m <= HALF_CIRC_M)
        else $error("distance above half circumference");

    // Flag agrees with the distance and the written radius
    a_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> within_radius == (distance_m < shadow_reg))
        else $error("within_radius disagrees with distance and radius");

    // Input stalls only behind a stalled result
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

endmodule

bind great_circle_distance_check_core gcd_checker u_gcd_checker (.*);

// File: bench/tb_great_circle_distance_check_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_great_circle_distance_check_core
// Drives point pairs into the distance pipeline under random idling and
// stalls. It computes each expected distance and radius flag with a local
// fixed-point model and checks every result in order.
// ----------------------------------------------------------------------------
module tb_great_circle_distance_check_core;
    import gcd_pkg::*;

    localparam int LATENCY   = 97;
    localparam int WDOG_MAX  = 4000;
    localparam longint PI_Q32_L  = 64'd13493037705;
    localparam longint PI_Q30_L  = 64'd3373259426;
    localparam longint K_L       = 64'd652032874;
    localparam longint MPR_L     = 64'd3261795065;
    localparam longint HALF_M    = 64'd20014124;
    localparam longint DEG90     = 64'd90000000;
    localparam longint DEG180    = 64'd180000000;
    localparam longint DEG360    = 64'd360000000;
    localparam longint DIVQ      = 64'd720000000;

    typedef struct {
        dist_t dist_m;
        logic  flag;
    } dist_res_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_stall;
    lat_t  lat_a = '0, lat_b = '0;
    lon_t  lon_a = '0, lon_b = '0;
    logic  out_valid;
    logic  out_stall = 1'b0;
    dist_t distance_m;
    logic  within_radius;
    logic  cfg_wr_en = 1'b0;
    dist_t cfg_wr_data = '0;

    dist_res_t dist_q[$];
    longint    radius_cur = 500;
    int        mismatches = 0;
    int        n_sent = 0;
    int        n_seen = 0;
    int        idle_pct = 32;
    int        wdog = 0;
    bit        timed_out = 1'b0;

    great_circle_distance_check_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
        .out_valid(out_valid), .out_stall(out_stall),
        .distance_m(distance_m), .within_radius(within_radius),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Arithmetic shift right, floor semantics
    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_tab(int i);
        longint head[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                             33543516, 16775851, 8388437, 4194283, 2097149};
        if (i < 10) return head[i];
        if (i <= 30) return longint'(1) << (30 - i);
        return 0;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b + (longint'(1) << 29)) >>> 30;
    endfunction

    // Sine and cosine of a microdegree angle, Q30
    function automatic void udeg_sincos(longint ud, output longint s, output longint c);
        longint r, mag, z, x, y, dx, dy;
        bit     flip;
        r = ud % DEG360;
        flip = 1'b0;
        x = K_L;
        y = 0;
        if (r < 0) r += DEG360;
        if (r >= DEG180) r -= DEG360;
        if (r > DEG90)
        begin
            r = DEG180 - r;
            flip = 1'b1;
        end
        else if (r < -DEG90)
        begin
            r = -DEG180 - r;
            flip = 1'b1;
        end
        mag = (r < 0) ? -r : r;
        z = (mag * PI_Q32_L + DIVQ / 2) / DIVQ;
        if (r < 0) z = -z;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            dx = shr(y, i);
            dy = shr(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_tab(i);
            end
            else
            begin
                x += dx; y -= dy; z += atan_tab(i);
            end
        end
        s = y;
        c = flip ? -x : x;
    endfunction

    function automatic longint int_sqrt(longint unsigned t);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > t) b >>= 2;
        while (b != 0)
        begin
            if (t >= res + b)
            begin
                t -= res + b;
                res = (res >> 1) + b;
            end
            else res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint arc_cos(longint v);
        longint x, y, z, th, dx, dy;
        x = (v < 0) ? -v : v;
        y = int_sqrt(longint'(64'd1 << 60) - v * v);
        z = 0;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            dx = shr(y, i);
            dy = shr(x, i);
            if (y > 0)
            begin
                x += dx; y -= dy; z += atan_tab(i);
            end
            else
            begin
                x -= dx; y += dy; z -= atan_tab(i);
            end
        end
        th = (v < 0) ? PI_Q30_L - z : z;
        if (th < 0) th = 0;
        if (th > PI_Q30_L) th = PI_Q30_L;
        return th;
    endfunction

    function automatic dist_res_t pair_distance(lat_t la, lon_t oa, lat_t lb, lon_t ob);
        longint sa, ca, sb, cb, sd, cd, v, th;
        longint unsigned d;
        dist_res_t r;
        udeg_sincos(longint'(la), sa, ca);
        udeg_sincos(longint'(lb), sb, cb);
        udeg_sincos(longint'(oa) - longint'(ob), sd, cd);
        v = qmul(sa, sb) + qmul(qmul(ca, cb), cd);
        if (v > (longint'(1) << 30)) v = longint'(1) << 30;
        if (v < -(longint'(1) << 30)) v = -(longint'(1) << 30);
        th = arc_cos(v);
        d = (longint'(th) * MPR_L + (longint'(1) << 38)) >> 39;
        if (d > HALF_M) d = HALF_M;
        r.dist_m = dist_t'(d);
        r.flag = (d < radius_cur);
        return r;
    endfunction

    // Send one point pair and record its expected result at acceptance;
    // valid stays high so the next item can follow with no gap
    task automatic send_pair(lat_t la, lon_t oa, lat_t lb, lon_t ob);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        lat_a <= la; lon_a <= oa; lat_b <= lb; lon_b <= ob;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        dist_q.push_back(pair_distance(la, oa, lb, ob));
        n_sent++;
        @(negedge clk);
    endtask

    // Random stall on the result side
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < idle_pct);

    // Check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        dist_res_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            n_seen++;
            if (dist_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %0d", distance_m);
            end
            else
            begin
                e = dist_q.pop_front();
                if (distance_m !== e.dist_m || within_radius !== e.flag)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp dist %0d flag %0b, got dist %0d flag %0b",
                                 e.dist_m, e.flag, distance_m, within_radius);
                end
            end
        end
    end

    // Watchdog: count cycles without any acceptance
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) wdog <= 0;
        else if (in_valid || dist_q.size() != 0) wdog <= wdog + 1;
        if (wdog >= WDOG_MAX && !timed_out)
        begin
            timed_out = 1'b1;
            $display("watchdog expired");
            $display("simulation failed");
            $finish;
        end
    end

    // Drop valid and wait until every item has left the pipeline
    task automatic drain();
        in_valid <= 1'b0;
        while (dist_q.size() != 0) @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    task automatic set_radius(longint r);
        drain();
        cfg_wr_data <= dist_t'(r);
        cfg_wr_en <= 1'b1;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        radius_cur = r;
    endtask

    function automatic lat_t rand_lat();
        return lat_t'($signed($urandom_range(180000000)) - 90000000);
    endfunction

    function automatic lon_t rand_lon();
        return lon_t'($signed($urandom_range(360000000)) - 180000000);
    endfunction

    // Extremes, coincident and antipodal points, wrap cases
    task automatic test_directed();
        send_pair(0, 0, 0, 0);
        send_pair(lat_t'(90000000), 0, lat_t'(-90000000), 0);
        send_pair(lat_t'(-90000000), lon_t'(180000000), lat_t'(-90000000), lon_t'(-180000000));
        send_pair(0, 0, 0, lon_t'(180000000));
        send_pair(0, lon_t'(-180000000), 0, lon_t'(180000000));
        send_pair(lat_t'(45000000), lon_t'(10000000), lat_t'(45000000), lon_t'(10000001));
        send_pair(lat_t'(48856600), lon_t'(2352200), lat_t'(48860000), lon_t'(2350000));
        send_pair(lat_t'(12345678), lon_t'(-98765432), lat_t'(12345678), lon_t'(-98765432));
        send_pair(lat_t'(-45000000), 0, lat_t'(45000000), lon_t'(180000000));
        // Out-of-range fields wrap modulo a full turn
        send_pair(lat_t'(134217727), lon_t'(268435455), lat_t'(-134217728), lon_t'(-268435456));
        send_pair(lat_t'(-1), lon_t'(-1), lat_t'(1), lon_t'(1));
        send_pair(lat_t'(100000000), 0, lat_t'(80000000), 0);
        send_pair(lat_t'(-134217728), lon_t'(-268435456), lat_t'(134217727), lon_t'(268435455));
        send_pair(0, lon_t'(90000000), 0, lon_t'(-90000000));
    endtask

    // Small separations, antipodal pairs and out-of-range fields, mixed with global pairs
    task automatic test_random(int n);
        lat_t la, lb;
        lon_t oa, ob;
        for (int k = 0; k < n; k++)
        begin
            la = rand_lat();
            oa = rand_lon();
            case ($urandom_range(9))
                0:
                begin
                    lb = lat_t'($urandom);
                    ob = lon_t'($urandom);
                    la = lat_t'($urandom);
                    oa = lon_t'($urandom);
                end
                1, 2, 3, 4:
                begin
                    lb = la + lat_t'($signed($urandom_range(20000)) - 10000);
                    ob = oa + lon_t'($signed($urandom_range(20000)) - 10000);
                end
                5:
                begin
                    lb = -la;
                    ob = oa + lon_t'(180000000);
                end
                default:
                begin
                    lb = rand_lat();
                    ob = rand_lon();
                end
            endcase
            send_pair(la, oa, lb, ob);
        end
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        set_radius(0);
        test_random(80);
        set_radius(25'h1FFFFFF);
        test_random(80);
        set_radius(20015000);
        test_random(60);
        // Hold both sides busy for a long stretch
        idle_pct = 0;
        set_radius(1000);
        test_random(140);
        idle_pct = 32;
        set_radius(500);
        test_random(140);
        drain();
        $display("sent %0d point pairs, checked %0d distances over 6 radius settings",
                 n_sent, n_seen);
        if (mismatches == 0 && dist_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// File: sim.f
sv/gcd_pkg.sv
sv/gcd_angle.sv
sv/gcd_sincos.sv
sv/gcd_acos.sv
sv/great_circle_distance_check_core.sv
sv/gcd_checker.sv
bench/tb_great_circle_distance_check_core.sv
